// ===== hdl/ihex_pkg.sv =====
`default_nettype none

package ihex_pkg;

  // Result kinds carried on the output channel
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_GOOD  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // Record types that the parser acts on
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] write_addr;
    logic [7:0]  write_data;
    logic        file_done;
  } ihex_res_t;

  // Lax hex digit: letters (bit 6 set) get 9 added, keep the low nibble
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = c[6] ? (c + 8'd9) : c;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/intel_hex_record_decoder.sv =====
`default_nettype none

// Channel  | Direction | Ports                               | Payload
// ---------+-----------+-------------------------------------+-------------------------------
// in       | slave     | in_tvalid, in_tready, in_tdata      | one received character
// out      | master    | out_tvalid, out_tready, out_tdata,  | memory write or checksum ack
//          |           | out_tuser, out_tlast                |
// cfg      | slave     | cfg_valid, cfg_ready, cfg_data      | load_offset register write
//
// Each character is held in the input register, then makes one pass through
// the record parser into a two-entry result queue; one character per cycle is
// sustained while the consumer keeps out_tready high.
// in_tready depends only on registers, so no combinational path joins out_tready
// to in_tready; the result queue absorbs the delay of that registered decision.
// Reset is synchronous, active low, and clears parser state, the queue and
// load_offset. cfg_ready is always high.
// After an end-of-file record the parser drops all characters until reset.

module intel_hex_record_decoder (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata[7:0]: rx_char
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,
  // out_tdata[31:0]: write_addr, out_tdata[39:32]: write_data
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,
  // out_tuser[1:0]: out_kind
  output logic [1:0]  out_tuser,
  // out_tlast: file_done
  output logic        out_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data
);

  logic [7:0]  char_r;
  logic        char_vld_r;
  logic [31:0] load_offset_r;

  logic                q_full;
  logic                q_valid;
  logic                parse_go;
  logic                res_vld;
  logic                push;
  logic                pop;
  ihex_pkg::ihex_res_t res;
  ihex_pkg::ihex_res_t head;

  // Advance the held character into the parser when the queue has room
  assign parse_go  = char_vld_r && !q_full;
  assign in_tready = !char_vld_r || !q_full;
  assign push      = res_vld;
  assign pop       = q_valid && out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
    end else if (in_tready) begin
      char_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_offset_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      load_offset_r <= cfg_data;
    end
  end

  ihex_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (parse_go),
    .rx_char     (char_r),
    .load_offset (load_offset_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  ihex_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .valid     (q_valid),
    .full      (q_full),
    .head      (head)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = {head.write_data, head.write_addr};
  assign out_tuser  = head.out_kind;
  assign out_tlast  = head.file_done;

  // A result only comes from a character that was actually consumed
  a_push_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> parse_go)
    else $error("result produced without a consumed character");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("result queue overflow");

  // Nothing follows the end-of-file acknowledge
  a_eof_final: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.file_done) |=> !push)
    else $error("result after end of file");

  // Only writes carry address or data
  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.out_kind != ihex_pkg::KIND_WRITE) |->
      (res.write_addr == 32'd0 && res.write_data == 8'd0))
    else $error("acknowledge carries payload");

endmodule

`default_nettype wire

// ===== hdl/ihex_parse.sv =====
`default_nettype none

module ihex_parse (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   go,
  input  wire [7:0]             rx_char,
  input  wire [31:0]            load_offset,
  output logic                  res_vld,
  output ihex_pkg::ihex_res_t   res
);

  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_ADDR_HI = 3'd2;
  localparam logic [2:0] PH_ADDR_LO = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic        second_r, second_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] addr_lo_r, addr_lo_nxt;
  logic [7:0]  rkind_r, rkind_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic [31:0] upper_r, upper_nxt;
  logic [31:0] wbase_r, wbase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        fin_r, fin_nxt;

  logic [3:0]  dig;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic [7:0]  idx_inc;

  assign dig      = ihex_pkg::hex_digit(rx_char);
  assign byte_val = {hi_r, dig};
  assign sum_add  = sum_r + byte_val;
  assign idx_inc  = idx_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    second_nxt  = second_r;
    hi_nxt      = hi_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    addr_lo_nxt = addr_lo_r;
    rkind_nxt   = rkind_r;
    ext_nxt     = ext_r;
    upper_nxt   = upper_r;
    wbase_nxt   = wbase_r;
    sum_nxt     = sum_r;
    fin_nxt     = fin_r;
    res_vld     = 1'b0;
    res         = '0;

    if (go && !fin_r) begin
      if (phase_r == PH_WAIT || phase_r > PH_CHECK) begin
        if (rx_char == ihex_pkg::CHAR_COLON) begin
          phase_nxt  = PH_LENGTH;
          second_nxt = 1'b0;
          sum_nxt    = 8'd0;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end else if (!second_r) begin
        hi_nxt     = dig;
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        sum_nxt    = sum_add;
        unique case (phase_r)
          PH_LENGTH: begin
            len_nxt   = byte_val;
            phase_nxt = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            addr_lo_nxt = {byte_val, 8'd0};
            phase_nxt   = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            addr_lo_nxt = {addr_lo_r[15:8], byte_val};
            phase_nxt   = PH_TYPE;
          end
          PH_TYPE: begin
            rkind_nxt = byte_val;
            idx_nxt   = 8'd0;
            // upper base cannot move inside a data record: fold it in now
            wbase_nxt = upper_r + {16'd0, addr_lo_r};
            phase_nxt = (len_r == 8'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            if (rkind_r == ihex_pkg::REC_DATA) begin
              res_vld         = 1'b1;
              res.out_kind    = ihex_pkg::KIND_WRITE;
              res.write_addr  = wbase_r + load_offset + {24'd0, idx_r};
              res.write_data  = byte_val;
            end else if (rkind_r == ihex_pkg::REC_EXT_SEG ||
                         rkind_r == ihex_pkg::REC_EXT_LIN) begin
              if (idx_r == 8'd0) begin
                ext_nxt = byte_val;
              end else if (idx_r == 8'd1) begin
                upper_nxt = (rkind_r == ihex_pkg::REC_EXT_SEG) ?
                            {12'd0, ext_r, byte_val, 4'd0} :
                            {ext_r, byte_val, 16'd0};
              end
            end
            if (idx_inc == len_r) begin
              phase_nxt = PH_CHECK;
            end
            idx_nxt = idx_inc;
          end
          default: begin
            res_vld       = 1'b1;
            res.out_kind  = (sum_add == 8'd0) ? ihex_pkg::KIND_GOOD : ihex_pkg::KIND_BAD;
            res.file_done = (rkind_r == ihex_pkg::REC_EOF);
            fin_nxt       = (rkind_r == ihex_pkg::REC_EOF);
            phase_nxt     = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      second_r  <= 1'b0;
      hi_r      <= 4'd0;
      len_r     <= 8'd0;
      idx_r     <= 8'd0;
      addr_lo_r <= 16'd0;
      rkind_r   <= 8'd0;
      ext_r     <= 8'd0;
      upper_r   <= 32'd0;
      wbase_r   <= 32'd0;
      sum_r     <= 8'd0;
      fin_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      second_r  <= second_nxt;
      hi_r      <= hi_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
      addr_lo_r <= addr_lo_nxt;
      rkind_r   <= rkind_nxt;
      ext_r     <= ext_nxt;
      upper_r   <= upper_nxt;
      wbase_r   <= wbase_nxt;
      sum_r     <= sum_nxt;
      fin_r     <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ihex_ofifo.sv =====
`default_nettype none

module ihex_ofifo (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire ihex_pkg::ihex_res_t   push_data,
  input  wire                        pop,
  output logic                       valid,
  output logic                       full,
  output ihex_pkg::ihex_res_t        head
);

  ihex_pkg::ihex_res_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire
